### rtl/core/bounded_deque_with_removal_macros.svh
// Assertion macros for the deque design.
`ifndef BOUNDED_DEQUE_WITH_REMOVAL_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REMOVAL_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define BDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define BDQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/bdq_pkg.sv
// Package with the sizes, codes and word types of the deque.
package bdq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int OP_W       = 3;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 4;
   localparam int LEN_W      = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE     = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_WAIT,
      S_SHIFT_RD,
      S_SHIFT_WR
   } bdq_state_type;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [VALUE_W-1:0] item_value;
      logic [POS_W-1:0]          position;
   } req_payload_type;

   typedef struct packed {
      logic                      ok;
      logic signed [VALUE_W-1:0] popped_value;
      logic [LEN_W-1:0]          length_after;
   } rsp_payload_type;

endpackage

### rtl/core/bdq_req_if.sv
// Request channel interface of the deque.
interface bdq_req_if
   import bdq_pkg::*;
;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/bdq_rsp_if.sv
// Response channel interface of the deque.
interface bdq_rsp_if
   import bdq_pkg::*;
;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/bounded_deque_with_removal.sv
// Bounded deque with removal by position, built around one ring memory.
//
//   channel    dir  word
//   req_chan   in   operation, item_value, position
//   rsp_chan   out  ok, popped_value, length_after
//
// A push or a rejected request goes through the exec state to the response register;
// a pop also waits for its memory read. In a removal each word behind the gap is read
// in the shift-read state and written one slot nearer the front in the shift-write state.
// A new word is accepted as soon as the sequencer is idle, even while the previous
// response waits in its output register; the next completion waits for that register.
// Reset (synchronous) empties the deque; the memory contents need no clearing.
`include "bounded_deque_with_removal_macros.svh"

module bounded_deque_with_removal
   import bdq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_chan,
   bdq_rsp_if.source rsp_chan
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   bdq_state_type         state_ff, state_in;
   logic [OP_W-1:0]       op_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [PTR_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      k_ff, k_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [VALUE_W-1:0]    rsp_pop_ff, rsp_pop_in;
   logic [LEN_W-1:0]      rsp_len_ff, rsp_len_in;

   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [PTR_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic                  accept;
   logic                  rsp_free;
   logic [CNT_W-1:0]      k_next;
   logic [VALUE_W-1:0]    rd_wide;

   // Ring slot of a logical position relative to the front.
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                                input logic [PTR_W-1:0] logical);
      logic [PTR_W:0] sum;
      sum = {1'b0, front} + {1'b0, logical};
      if (sum >= (PTR_W+1)'(DEPTH)) begin
         sum = sum - (PTR_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign k_next   = k_ff + CNT_W'(1);
   assign rd_wide  = VALUE_W'($signed(rd_data_ff));

   assign req_chan.ready                 = (state_ff == S_IDLE);
   assign rsp_chan.valid                 = rsp_valid_ff;
   assign rsp_chan.payload.ok            = rsp_ok_ff;
   assign rsp_chan.payload.popped_value  = rsp_pop_ff;
   assign rsp_chan.payload.length_after  = rsp_len_ff;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_pop_in   = rsp_pop_ff;
      rsp_len_in   = rsp_len_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_of(front_ff, k_ff[PTR_W-1:0]);
      wr_data      = rd_data_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (rsp_free) begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                     rsp_pop_in   = '0;
                     if (int'(count_ff) < DEPTH) begin
                        wr_en   = 1'b1;
                        wr_data = word_ff;
                        if (op_ff == OP_PUSH_FRONT) begin
                           front_in = (front_ff == '0) ? PTR_W'(DEPTH - 1)
                                                       : front_ff - PTR_W'(1);
                           wr_addr  = front_in;
                        end else begin
                           wr_addr  = slot_of(front_ff, count_ff[PTR_W-1:0]);
                        end
                        count_in   = count_ff + CNT_W'(1);
                        rsp_ok_in  = 1'b1;
                     end else begin
                        rsp_ok_in  = 1'b0;
                     end
                     rsp_len_in = LEN_W'(count_in);
                  end
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (count_ff != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = (op_ff == OP_POP_FRONT) ? front_ff :
                        slot_of(front_ff, PTR_W'(count_ff - CNT_W'(1)));
                     state_in = S_POP_WAIT;
                  end else if (rsp_free) begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b0;
                     rsp_pop_in   = '0;
                     rsp_len_in   = LEN_W'(count_ff);
                  end
               end
               OP_REMOVE: begin
                  if (int'(pos_ff) < int'(count_ff)) begin
                     k_in     = CNT_W'(pos_ff);
                     state_in = S_SHIFT_RD;
                  end else if (rsp_free) begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b0;
                     rsp_pop_in   = '0;
                     rsp_len_in   = LEN_W'(count_ff);
                  end
               end
               default: begin
                  // Unused operation codes are rejected with no change.
                  if (rsp_free) begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b0;
                     rsp_pop_in   = '0;
                     rsp_len_in   = LEN_W'(count_ff);
                  end
               end
            endcase
         end
         S_POP_WAIT: begin
            if (rsp_free) begin
               state_in     = S_IDLE;
               if (op_ff == OP_POP_FRONT) begin
                  front_in = slot_of(front_ff, PTR_W'(1));
               end
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_pop_in   = rd_wide;
               rsp_len_in   = LEN_W'(count_in);
            end
         end
         S_SHIFT_RD: begin
            if (k_next < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = slot_of(front_ff, k_next[PTR_W-1:0]);
               state_in = S_SHIFT_WR;
            end else if (rsp_free) begin
               state_in     = S_IDLE;
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_pop_in   = '0;
               rsp_len_in   = LEN_W'(count_in);
            end
         end
         S_SHIFT_WR: begin
            // The word read from the next slot closes the gap at slot k.
            wr_en    = 1'b1;
            k_in     = k_next;
            state_in = S_SHIFT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_chan.payload.operation;
         word_ff <= DATA_WIDTH'($unsigned(req_chan.payload.item_value));
         pos_ff  <= req_chan.payload.position;
      end
      k_ff       <= k_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_pop_ff <= rsp_pop_in;
      rsp_len_ff <= rsp_len_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   `BDQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, int'(count_ff) <= DEPTH)
   `BDQ_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == S_EXEC)
   `BDQ_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == S_IDLE, !wr_en)
   `BDQ_ASSERT_NOW(a_shift_in_range, clock, reset, state_ff == S_SHIFT_WR, k_next < count_ff)

endmodule

### sim/tb_bounded_deque_with_removal.sv
// Self-checking testbench for the bounded deque with removal by position.
`timescale 1ns / 1ps

module tb_bounded_deque_with_removal;
   import bdq_pkg::*;

   localparam int RANDOM_OPS   = 1300;
   localparam int QUIET_TAIL   = 150;
   localparam int HOLD_START   = 300;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 40;
   localparam int TIMEOUT_NS   = 2_000_000;

   logic clock;
   logic reset;

   bdq_req_if req_bus ();
   bdq_rsp_if rsp_bus ();

   bounded_deque_with_removal i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Stimulus and scoreboard storage.
   req_payload_type pending_ops[$];
   rsp_payload_type owed_replies[$];
   int              ops_sent;
   int              error_count;
   int              gen_len;
   logic            req_taken;
   logic            hold_rsp;
   int              send_gap;
   int              stall_left;

   // Shadow copy of the deque contents.
   logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
   int unsigned           head_idx;
   int unsigned           fill_cnt;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic rsp_payload_type apply_deque_op(req_payload_type w);
      rsp_payload_type r;
      op_type          op;
      int unsigned     k;
      r  = '0;
      op = op_type'(w.operation);
      case (op)
         OP_PUSH_FRONT: begin
            if (fill_cnt < DEPTH) begin
               head_idx = (head_idx + DEPTH - 1) % DEPTH;
               ring_mem[head_idx] = w.item_value[DATA_WIDTH-1:0];
               fill_cnt++;
               r.ok = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (fill_cnt < DEPTH) begin
               ring_mem[(head_idx + fill_cnt) % DEPTH] = w.item_value[DATA_WIDTH-1:0];
               fill_cnt++;
               r.ok = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (fill_cnt > 0) begin
               r.popped_value = VALUE_W'($signed(ring_mem[head_idx]));
               head_idx = (head_idx + 1) % DEPTH;
               fill_cnt--;
               r.ok = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (fill_cnt > 0) begin
               r.popped_value =
                  VALUE_W'($signed(ring_mem[(head_idx + fill_cnt - 1) % DEPTH]));
               fill_cnt--;
               r.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            // Entries behind the removed one each move one place towards the front.
            if (w.position < fill_cnt) begin
               for (k = w.position; k + 1 < fill_cnt; k++) begin
                  ring_mem[(head_idx + k) % DEPTH] = ring_mem[(head_idx + k + 1) % DEPTH];
               end
               fill_cnt--;
               r.ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.length_after = fill_cnt[LEN_W-1:0];
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Queues one word and keeps a running length so that the random part can steer.
   task automatic queue_word(input op_type op, input logic [VALUE_W-1:0] value,
                             input logic [POS_W-1:0] pos);
      req_payload_type w;
      w.operation  = op;
      w.item_value = value;
      w.position   = pos;
      pending_ops  = {pending_ops, w};
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (gen_len < DEPTH) gen_len++;
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (gen_len > 0) gen_len--;
         end
         OP_REMOVE: begin
            if (pos < gen_len) gen_len--;
         end
         default: begin
         end
      endcase
   endtask

   // Request driver: a word stays on the bus until it is taken.
   always @(negedge clock) begin
      logic holding;
      logic quiet;
      holding = req_bus.valid && !req_taken;
      quiet   = pending_ops.size() < QUIET_TAIL;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_taken) begin
            pending_ops.delete(0);
            ops_sent++;
            if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
         end
         if (holding) begin
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            req_bus.valid   <= 1'b1;
            req_bus.payload <= pending_ops[0];
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure.
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (pending_ops.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted response.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type guess;
      req_taken <= req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            guess        = apply_deque_op(req_bus.payload);
            owed_replies = {owed_replies, guess};
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (owed_replies.size() == 0) begin
               $error("response word arrived with no request outstanding");
               error_count++;
            end else begin
               want = owed_replies[0];
               owed_replies.delete(0);
               if (rsp_bus.payload.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, rsp_bus.payload.ok);
                  error_count++;
               end
               if (rsp_bus.payload.popped_value !== want.popped_value) begin
                  $error("popped_value: expected %0d, got %0d",
                         want.popped_value, rsp_bus.payload.popped_value);
                  error_count++;
               end
               if (rsp_bus.payload.length_after !== want.length_after) begin
                  $error("length_after: expected %0d, got %0d",
                         want.length_after, rsp_bus.payload.length_after);
                  error_count++;
               end
            end
         end
      end
   end

   // Long hold-off on the response side, so that the deque backs up onto its input.
   initial begin
      hold_rsp = 1'b0;
      while (ops_sent < HOLD_START) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL bounded_deque_with_removal");
      $finish;
   end

   initial begin
      int              total;
      int              roll;
      int              push_cut;
      int              pop_cut;
      logic            fill_mode;
      logic [POS_W-1:0] pos;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      req_taken       = 1'b0;
      ops_sent        = 0;
      error_count     = 0;
      gen_len         = 0;
      send_gap        = 0;
      stall_left      = 0;
      head_idx        = 0;
      fill_cnt        = 0;

      // Empty deque: pops and removal must all be refused.
      queue_word(OP_POP_FRONT, pick_value(), '0);
      queue_word(OP_POP_BACK, pick_value(), '0);
      queue_word(OP_REMOVE, pick_value(), '0);
      // Fill from both ends, so that the ring wraps, with the extreme words first.
      queue_word(OP_PUSH_FRONT, 32'h8000_0000, '0);
      queue_word(OP_PUSH_BACK, 32'h7FFF_FFFF, '0);
      queue_word(OP_PUSH_FRONT, '1, '0);
      queue_word(OP_PUSH_BACK, '0, '0);
      repeat (12) queue_word(op_type'($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK),
                             $urandom, '0);
      // Full deque: pushes fail, then removals at the last, beyond, front and middle.
      queue_word(OP_PUSH_BACK, pick_value(), '0);
      queue_word(OP_PUSH_FRONT, pick_value(), '0);
      queue_word(OP_REMOVE, pick_value(), 4'd15);
      queue_word(OP_REMOVE, pick_value(), 4'd15);
      queue_word(OP_REMOVE, pick_value(), 4'd0);
      queue_word(OP_REMOVE, pick_value(), 4'd7);
      queue_word(OP_POP_FRONT, pick_value(), '0);
      queue_word(OP_POP_BACK, pick_value(), '0);

      // Random part alternates between filling and draining spells.
      fill_mode = 1'b1;
      repeat (RANDOM_OPS) begin
         roll = $urandom_range(0, 99);
         if (gen_len == DEPTH && $urandom_range(0, 3) == 0) fill_mode = 1'b0;
         else if (gen_len == 0 && $urandom_range(0, 3) == 0) fill_mode = 1'b1;
         else if ($urandom_range(0, 63) == 0) fill_mode = !fill_mode;
         push_cut = fill_mode ? 65 : 20;
         pop_cut  = fill_mode ? 80 : 75;
         if (roll < push_cut) begin
            queue_word(op_type'($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK),
                       pick_value(), POS_W'($urandom_range(0, 15)));
         end else if (roll < pop_cut) begin
            queue_word(op_type'($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK),
                       pick_value(), POS_W'($urandom_range(0, 15)));
         end else begin
            if (gen_len > 0 && $urandom_range(0, 4) != 0) begin
               pos = POS_W'($urandom_range(0, gen_len - 1));
            end else begin
               pos = POS_W'($urandom_range(0, 15));
            end
            queue_word(OP_REMOVE, pick_value(), pos);
         end
      end
      total = pending_ops.size();

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      while (ops_sent < total) @(posedge clock);
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS bounded_deque_with_removal");
      end else begin
         $display("FAIL bounded_deque_with_removal");
      end
      $finish;
   end

endmodule
